// ----- sv/sensor_history_feature_extractor_core_defines.svh -----
`ifndef SENSOR_HISTORY_FEATURE_EXTRACTOR_CORE_DEFINES_SVH
`define SENSOR_HISTORY_FEATURE_EXTRACTOR_CORE_DEFINES_SVH

// same-cycle check, off while rst is high
`define SHD_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check, off while rst is high
`define SHD_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/shd_pkg.sv -----
`default_nettype none

package shd_pkg;

  // one history slot
  typedef struct packed {
    logic              valid;
    logic signed [10:0] temp;
    logic        [8:0]  moist;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_CALC
  } state_t;

  localparam logic [8:0] MOIST_OFFSET = 9'd50;
  localparam logic [7:0] PCT_MAX      = 8'd100;

endpackage

`default_nettype wire

// ----- sv/sensor_history_feature_extractor_core.sv -----
// Sensor history feature extractor.
// Input channel s_*: one word per sensor reading. A reading with all three
// fields zero is not stored; any other goes into a chain of DEPTH history
// cells (newest in cell 0) and into running temperature and moisture sums.
// Output channel m_*: exactly one result word per input word, in order,
// with the newest values, means, trends and moisture lags 1 and 2.
// After a reading is taken, a start state launches the two bit-serial
// dividers that form the means (dividends of 11 + clog2(DEPTH) bits for
// temperature, 13 + clog2(DEPTH) bits for moisture); the result is loaded
// into the output register once both are done. One reading is worked on
// at a time. The next reading is taken as soon as the result sits in the
// output register, even if the receiver has not taken it yet.
// If m_tready is low, the result holds and the next finished result waits
// in the dividers until the output register is free.
// Reset (rst, synchronous) empties the history, clears the sums and the
// fill count, and drops any pending result.
`default_nettype none

module sensor_history_feature_extractor_core
  import shd_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [10:0] temperature_tenths, [17:11] humidity_percent,
  // [25:18] moisture_percent, [31:26] zero
  input  wire logic [31:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [0] stored, [1] history_full, [12:2] temp_now, [21:13] moisture_now,
  // [32:22] temp_average, [45:33] moisture_average_x16, [57:46] temp_slope,
  // [67:58] moisture_slope, [76:68] moisture_prev1, [85:77] moisture_prev2,
  // [87:86] zero
  output logic [87:0]      m_tdata
);

  `include "sensor_history_feature_extractor_core_defines.svh"

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int TSUM_W = 11 + $clog2(DEPTH);
  localparam int MSUM_W = 9 + $clog2(DEPTH);
  localparam int MDIV_W = MSUM_W + 4;

  state_t state, state_next;

  entry_t cell_q [DEPTH];
  entry_t new_entry;

  logic signed [10:0]       temperature_tenths;
  logic [6:0]               humidity_percent;
  logic [7:0]               moisture_percent;
  logic [7:0]               pct_clamped;
  logic                     stored_in;
  logic                     accept;
  logic                     shift;
  logic                     full;

  logic [CNT_W-1:0]         fill_count;
  logic signed [TSUM_W-1:0] temp_sum;
  logic [MSUM_W-1:0]        moisture_sum;
  logic signed [TSUM_W-1:0] temp_drop;
  logic [MSUM_W-1:0]        moist_drop;
  logic                     stored_q;

  logic                     div_start;
  logic                     load_out;
  logic [TSUM_W-1:0]        temp_mag;
  logic                     t_done;
  logic                     m_done;
  logic [TSUM_W-1:0]        t_quot;
  logic [MDIV_W-1:0]        m_quot;
  logic [TSUM_W-1:0]        t_avg_full;

  logic signed [10:0]       old_temp;
  logic [8:0]               old_moist;
  logic signed [10:0]       temp_now;
  logic [8:0]               moisture_now;
  logic signed [10:0]       temp_average;
  logic [12:0]              moisture_average_x16;
  logic signed [11:0]       temp_slope;
  logic signed [9:0]        moisture_slope;

  // input fields
  assign temperature_tenths = s_tdata[10:0];
  assign humidity_percent   = s_tdata[17:11];
  assign moisture_percent   = s_tdata[25:18];

  assign accept    = s_tvalid && s_tready;
  assign stored_in = (temperature_tenths != '0) || (humidity_percent != '0) ||
                     (moisture_percent != '0);
  assign shift     = accept && stored_in;
  assign full      = (fill_count == CNT_W'(DEPTH));

  // clamp and scale moisture
  always_comb begin
    pct_clamped         = (moisture_percent > PCT_MAX) ? PCT_MAX : moisture_percent;
    new_entry.valid     = 1'b1;
    new_entry.temp      = temperature_tenths;
    new_entry.moist     = MOIST_OFFSET + {pct_clamped[6:0], 2'b00};
  end

  // history chain, newest in cell 0
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      shd_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (new_entry),
        .q     (cell_q[k])
      );
    end else begin : g_body
      shd_cell u_cell (
        .clk   (clk),
        .rst   (rst),
        .shift (shift),
        .d     (cell_q[k-1]),
        .q     (cell_q[k])
      );
    end
  end

  // entry leaving the chain when full
  always_comb begin
    temp_drop  = full ? TSUM_W'(cell_q[DEPTH-1].temp) : '0;
    moist_drop = full ? MSUM_W'(cell_q[DEPTH-1].moist) : '0;
  end

  // fill count and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      temp_sum     <= '0;
      moisture_sum <= '0;
    end else if (shift) begin
      if (!full) begin
        fill_count <= fill_count + 1'b1;
      end
      temp_sum     <= temp_sum + TSUM_W'(temperature_tenths) - temp_drop;
      moisture_sum <= moisture_sum + MSUM_W'(new_entry.moist) - moist_drop;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stored_q <= stored_in;
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and control
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = !rst;
        if (s_tvalid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        div_start  = 1'b1;
        state_next = S_CALC;
      end
      S_CALC: begin
        if (t_done && m_done && (!m_tvalid || m_tready)) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // means by serial division
  assign temp_mag = temp_sum[TSUM_W-1] ? (~temp_sum + 1'b1) : temp_sum;

  shd_div #(.DW(TSUM_W), .VW(CNT_W)) u_tdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (temp_mag),
    .divisor  (fill_count),
    .done     (t_done),
    .quotient (t_quot)
  );

  shd_div #(.DW(MDIV_W), .VW(CNT_W)) u_mdiv (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({moisture_sum, 4'b0000}),
    .divisor  (fill_count),
    .done     (m_done),
    .quotient (m_quot)
  );

  // oldest valid cell, one-hot and-or select
  always_comb begin
    old_temp  = '0;
    old_moist = '0;
    for (int k = 0; k < DEPTH; k++) begin
      if (cell_q[k].valid && ((k == DEPTH - 1) || !cell_q[(k + 1) % DEPTH].valid)) begin
        old_temp  = old_temp | cell_q[k].temp;
        old_moist = old_moist | cell_q[k].moist;
      end
    end
  end

  // result fields
  always_comb begin
    temp_now     = cell_q[0].temp;
    moisture_now = cell_q[0].moist;
    t_avg_full   = temp_sum[TSUM_W-1] ? (~t_quot + 1'b1) : t_quot;
    if (fill_count == '0) begin
      temp_average         = '0;
      moisture_average_x16 = '0;
    end else begin
      temp_average         = t_avg_full[10:0];
      moisture_average_x16 = m_quot[12:0];
    end
    if (fill_count >= CNT_W'(2)) begin
      temp_slope     = {temp_now[10], temp_now} - {old_temp[10], old_temp};
      moisture_slope = {1'b0, moisture_now} - {1'b0, old_moist};
    end else begin
      temp_slope     = '0;
      moisture_slope = '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {2'b00, cell_q[2].moist, cell_q[1].moist, moisture_slope, temp_slope,
                  moisture_average_x16, temp_average, moisture_now, temp_now,
                  full, stored_q};
    end
  end

  // checks
  `SHD_CHECK(a_fill_max, 1'b1, fill_count <= CNT_W'(DEPTH), "fill count above depth")
  `SHD_CHECK(a_full_tail, 1'b1, cell_q[DEPTH-1].valid == full, "tail cell and fill disagree")
  `SHD_CHECK_NEXT(a_fill_step, shift && !full,
                  fill_count == $past(fill_count) + 1'b1, "fill count did not advance")
  `SHD_CHECK(a_load_done, load_out, t_done && m_done, "result loaded before divide end")

endmodule

`default_nettype wire

// ----- sv/shd_cell.sv -----
`default_nettype none

module shd_cell
  import shd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   shift,
  input  wire entry_t d,
  output entry_t      q
);

  // slot register, takes the entry on d (the newer neighbor's, or the new entry at the head) on a shift
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/shd_div.sv -----
`default_nettype none

module shd_div #(
  parameter int DW = 16,
  parameter int VW = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [DW-1:0]      quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [CW-1:0] cnt;
  logic          active;
  logic [VW:0]   rem_sh;
  logic          q_bit;
  logic [VW:0]   rem_sub;

  // one restoring step per cycle
  always_comb begin
    rem_sh  = {rem, quotient[DW-1]};
    q_bit   = (rem_sh >= {1'b0, divisor});
    rem_sub = rem_sh - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else if (start) begin
      active <= 1'b1;
      done   <= 1'b0;
      cnt    <= CW'(DW);
    end else if (active) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end
  end

  // datapath, dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (active) begin
      quotient <= {quotient[DW-2:0], q_bit};
      rem      <= q_bit ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
    end
  end

endmodule

`default_nettype wire
